FILE: rtl/u2u8_pkg.sv
// Shared types, constants and the UTF-8 encoding function of the UTF-16 to UTF-8 transcoder.
package u2u8_pkg;

	localparam int CP_W = 21;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [CP_W-1:0] CP_MAX      = 21'h10FFFF;
	localparam logic [CP_W-1:0] CP_REPLACE  = 21'h00FFFD;
	localparam logic [CP_W-1:0] CP_SUPP_BASE = 21'h010000;

	localparam logic [15:0] HIGH_FIRST = 16'hD800;
	localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
	localparam logic [15:0] LOW_FIRST  = 16'hDC00;
	localparam logic [15:0] LOW_LAST   = 16'hDFFF;

	localparam logic [CP_W-1:0] LIM_1BYTE = 21'h00007F;
	localparam logic [CP_W-1:0] LIM_2BYTE = 21'h0007FF;
	localparam logic [CP_W-1:0] LIM_3BYTE = 21'h00FFFF;

	localparam logic [2:0] CNT_ONE   = 3'd1;
	localparam logic [2:0] CNT_TWO   = 3'd2;
	localparam logic [2:0] CNT_THREE = 3'd3;
	localparam logic [2:0] CNT_FOUR  = 3'd4;

	// One queued request: a code point, optionally preceded by a replacement.
	typedef struct packed {
		logic            rep_first;
		logic [CP_W-1:0] cp;
	} entry_t;

	typedef struct packed {
		logic   push;
		entry_t entry;
	} push_t;

	typedef struct packed {
		logic   full;
		logic   head_valid;
		entry_t head;
	} queue_stat_t;

	typedef struct packed {
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic [7:0] b3;
		logic [2:0] count;
	} utf8_t;

	function automatic utf8_t utf8_encode(input logic [CP_W-1:0] cp);
		utf8_t r;
		r = '0;
		if (cp <= LIM_1BYTE) begin
			r.b0 = {1'b0, cp[6:0]};
			r.count = CNT_ONE;
		end else if (cp <= LIM_2BYTE) begin
			r.b0 = {3'b110, cp[10:6]};
			r.b1 = {2'b10, cp[5:0]};
			r.count = CNT_TWO;
		end else if (cp <= LIM_3BYTE) begin
			r.b0 = {4'b1110, cp[15:12]};
			r.b1 = {2'b10, cp[11:6]};
			r.b2 = {2'b10, cp[5:0]};
			r.count = CNT_THREE;
		end else begin
			r.b0 = {5'b11110, cp[20:18]};
			r.b1 = {2'b10, cp[17:12]};
			r.b2 = {2'b10, cp[11:6]};
			r.b3 = {2'b10, cp[5:0]};
			r.count = CNT_FOUR;
		end
		return r;
	endfunction

endpackage

FILE: rtl/u2u8_front.sv
// Front end: accepts requests, pairs surrogates and queues code points.
module u2u8_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  req_type,
	input  logic [31:0]           code_value,
	input  u2u8_pkg::queue_stat_t qstat,
	output u2u8_pkg::push_t       push
);
	import u2u8_pkg::*;

	logic        pend_valid_q;
	logic [9:0]  pend_bits_q;
	logic        accept;
	logic [15:0] unit;
	logic        is_high;
	logic        is_low;
	logic        cp_bad;
	logic [CP_W-1:0] cp_item;
	logic [CP_W-1:0] cp_pair;

	assign in_ready = !qstat.full;
	assign accept   = in_valid && in_ready;
	assign unit     = code_value[15:0];
	assign is_high  = (unit >= HIGH_FIRST) && (unit <= HIGH_LAST);
	assign is_low   = (unit >= LOW_FIRST) && (unit <= LOW_LAST);
	assign cp_bad   = (code_value > {11'd0, CP_MAX}) ||
	                  ((code_value >= {16'd0, HIGH_FIRST}) && (code_value <= {16'd0, LOW_LAST}));
	assign cp_item  = cp_bad ? CP_REPLACE : code_value[CP_W-1:0];
	assign cp_pair  = CP_SUPP_BASE + {1'b0, pend_bits_q, unit[9:0]};

	always_comb begin
		push = '0;
		if (accept) begin
			priority if (req_type) begin
				push.push = 1'b1;
				push.entry.cp = cp_item;
			end else if (is_high) begin
				push.push = pend_valid_q;
				push.entry.cp = CP_REPLACE;
			end else if (is_low) begin
				push.push = 1'b1;
				push.entry.cp = pend_valid_q ? cp_pair : CP_REPLACE;
			end else begin
				push.push = 1'b1;
				push.entry.rep_first = pend_valid_q;
				push.entry.cp = {5'd0, unit};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else if (accept && !req_type) begin
			pend_valid_q <= is_high;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !req_type && is_high) begin
			pend_bits_q <= unit[9:0];
		end
	end

	a_high_held: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !req_type && is_high |=> pend_valid_q)
		else $error("high surrogate not held");

endmodule

FILE: rtl/u2u8_queue.sv
// Short FIFO of decoded requests between the front and back ends.
module u2u8_queue #(
	parameter int Depth = u2u8_pkg::QUEUE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  u2u8_pkg::push_t       push,
	input  logic                  pop,
	output u2u8_pkg::queue_stat_t qstat
);
	import u2u8_pkg::*;

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	entry_t          mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] cnt_q;
	logic            do_push;
	logic            do_pop;

	assign qstat.full       = (cnt_q == CntW'(Depth));
	assign qstat.head_valid = (cnt_q != '0);
	assign qstat.head       = mem_q[rd_ptr_q];
	assign do_push          = push.push && !qstat.full;
	assign do_pop           = pop && qstat.head_valid;

	function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
		return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.entry;
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CntW'(Depth))
		else $error("queue count overflow");

endmodule

FILE: rtl/u2u8_back.sv
// Back end: expands queued requests into results and encodes them as UTF-8.
module u2u8_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  u2u8_pkg::queue_stat_t qstat,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [7:0]            utf8_byte0,
	output logic [7:0]            utf8_byte1,
	output logic [7:0]            utf8_byte2,
	output logic [7:0]            utf8_byte3,
	output logic [2:0]            byte_count,
	output logic                  last_result
);
	import u2u8_pkg::*;

	logic            out_valid_q;
	logic            phase_q;
	utf8_t           res_q;
	logic            last_q;
	logic            load;
	logic            emit_rep;
	logic [CP_W-1:0] cp_sel;

	assign load     = qstat.head_valid && (!out_valid_q || out_ready);
	assign emit_rep = qstat.head.rep_first && !phase_q;
	assign cp_sel   = emit_rep ? CP_REPLACE : qstat.head.cp;
	assign pop      = load && !emit_rep;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			phase_q     <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				phase_q     <= emit_rep;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q  <= utf8_encode(cp_sel);
			last_q <= !emit_rep;
		end
	end

	assign out_valid   = out_valid_q;
	assign utf8_byte0  = res_q.b0;
	assign utf8_byte1  = res_q.b1;
	assign utf8_byte2  = res_q.b2;
	assign utf8_byte3  = res_q.b3;
	assign byte_count  = res_q.count;
	assign last_result = last_q;

	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !last_q && out_ready |=> out_valid_q && last_q)
		else $error("second result of a pair missing");

	a_phase_head: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> qstat.head_valid && qstat.head.rep_first)
		else $error("pair phase without its queue entry");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (byte_count == CNT_ONE) || (byte_count == CNT_TWO) ||
		                (byte_count == CNT_THREE) || (byte_count == CNT_FOUR))
		else $error("byte count out of range");

endmodule

FILE: rtl/utf16_to_utf8_transcoder.sv
// Top level of the UTF-16 to UTF-8 transcoder.
// Accepts one request per cycle while its queue is not full: a UTF-16 code unit or a whole
// code point. High surrogates are held and paired with the following low surrogate; unpaired
// or invalid material becomes U+FFFD. Each result is one UTF-8 sequence of 1 to 4 bytes with
// its byte count; last_result marks the final result of a request. A non-surrogate code unit
// that follows an unpaired high surrogate yields two results, and a lone high surrogate
// yields none. A request's results are registered in the queue and then in the back end's
// output register. A QueueDepth-entry queue between the decode front end and the encode back
// end absorbs output stalls; input is refused only while that queue is full.
module utf16_to_utf8_transcoder #(
	parameter int QueueDepth = u2u8_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        req_type,
	input  logic [31:0] code_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  utf8_byte0,
	output logic [7:0]  utf8_byte1,
	output logic [7:0]  utf8_byte2,
	output logic [7:0]  utf8_byte3,
	output logic [2:0]  byte_count,
	output logic        last_result
);
	import u2u8_pkg::*;

	push_t       push;
	queue_stat_t qstat;
	logic        pop;

	u2u8_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.code_value (code_value),
		.qstat      (qstat),
		.push       (push)
	);

	u2u8_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.qstat  (qstat)
	);

	u2u8_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.qstat       (qstat),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.utf8_byte0  (utf8_byte0),
		.utf8_byte1  (utf8_byte1),
		.utf8_byte2  (utf8_byte2),
		.utf8_byte3  (utf8_byte3),
		.byte_count  (byte_count),
		.last_result (last_result)
	);

endmodule
